[rtl/hbr_pkg.sv]
// Shared constants for the H-bridge relay sequencer: sizes, scaling,
// configuration register indexes and drive mode codes.
// No dependencies.
package hbr_pkg;

  // Ring geometry and sample width.
  localparam int SAMPLES  = 200;
  localparam int ADC_BITS = 10;
  localparam int PTR_W    = $clog2(SAMPLES);

  // Running sum of the ring, wide enough for a ring of full-scale samples.
  localparam int SUM_MAX  = SAMPLES * ((2 ** ADC_BITS) - 1);
  localparam int SUM_W    = $clog2(SUM_MAX + 1);

  // Current scaling: sum * CUR_SCALE / (shunt * SAMPLES).
  localparam int CUR_SCALE   = 1074;
  localparam int SCALE_W     = $clog2(CUR_SCALE + 1);
  localparam int PROD_W      = SUM_W + SCALE_W;
  localparam int SHUNT_W     = 16;
  localparam int DIVR_W      = SHUNT_W + $clog2(SAMPLES + 1);
  localparam int DIV_CNT_W   = $clog2(PROD_W);

  // Field and register widths.
  localparam int DUTY_W      = 8;
  localparam int TICK_W      = 16;
  localparam int CUR_W       = 21;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 21;
  localparam logic [CUR_W-1:0] CUR_MAX = {CUR_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ADC_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_WAIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHUNT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_CURRENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_ENABLE  = 3'd4;

  // Drive mode codes as reported on mode_now.
  localparam logic [MODE_W-1:0] MODE_RUN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAIT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRIP = 2'd2;

endpackage

[rtl/hbr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/hbridge_relay_sequencer.sv]
// H-bridge drive sequencer with relay switching and shunt current monitoring.
// Depends on hbr_pkg and the generic RAM hbr_ram that holds the sample ring.
//
//   channel   handshake                 payload
//   -------   -----------------------   ------------------------------------------
//   input     in_valid / in_stall       adc_sample, target_direction, target_duty
//   output    out_valid / out_stall     forward_duty, backward_duty, relay_direction,
//                                       current_estimate, over_current, mode_now
//   config    cfg_write_en              cfg_index, cfg_data
//
// Each tick passes in order through acceptance, an update of the ring and running
// sum (only when a sample is taken), forming of the product and divisor, 29 steps
// of the restoring divider, and commit.
// The block takes one transaction at a time; in_stall is high from acceptance
// until the result is loaded into the output register. A waiting result does
// not block acceptance of the next tick, but commit waits while it is stalled.
// Synchronous reset clears all control state and the ring valid bits, so
// ring entries never written read as zero; no clearing pass is needed.
module hbridge_relay_sequencer
  import hbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADC_BITS-1:0]   adc_sample,
  input  logic                  target_direction,
  input  logic [DUTY_W-1:0]     target_duty,
  // Output channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DUTY_W-1:0]     forward_duty,
  output logic [DUTY_W-1:0]     backward_duty,
  output logic                  relay_direction,
  output logic [CUR_W-1:0]      current_estimate,
  output logic                  over_current,
  output logic [MODE_W-1:0]     mode_now
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0] state;

  // Configuration registers.
  logic [TICK_W-1:0]  adc_interval_ticks;
  logic [TICK_W-1:0]  relay_wait_ticks;
  logic [SHUNT_W-1:0] shunt_value;
  logic [CUR_W-1:0]   trip_current;
  logic               trip_enable;

  // Tick state.
  logic [SAMPLES-1:0] ring_valid;
  logic [PTR_W-1:0]   ring_pointer;
  logic [SUM_W-1:0]   sample_sum;
  logic [TICK_W-1:0]  interval_count;
  logic [MODE_W-1:0]  drive_mode;
  logic [TICK_W-1:0]  wait_count;
  logic               present_direction;
  logic [DUTY_W-1:0]  held_forward_duty;
  logic [DUTY_W-1:0]  held_backward_duty;

  // Latched input transaction.
  logic [ADC_BITS-1:0] sample;
  logic                want_dir;
  logic [DUTY_W-1:0]   want_duty;

  // Divider registers.
  logic [DIVR_W-1:0]    divisor;
  logic [DIVR_W-1:0]    rem;
  logic [PROD_W-1:0]    quo;
  logic [DIV_CNT_W-1:0] div_count;

  // Ring RAM signals.
  logic [ADC_BITS-1:0] ring_rdata;
  logic [PTR_W-1:0]    ring_raddr;
  logic                ring_we;

  logic accept;
  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  // Sample interval bookkeeping for the tick being accepted.
  logic [TICK_W-1:0] interval_eff;
  logic [TICK_W-1:0] ic_inc;
  logic              take_sample;
  logic [PTR_W-1:0]  ptr_next;

  always_comb begin
    interval_eff = (adc_interval_ticks == '0) ? TICK_W'(1) : adc_interval_ticks;
    ic_inc       = interval_count + TICK_W'(1);
    take_sample  = (ic_inc >= interval_eff) || (ic_inc == '0);
    ptr_next     = (ring_pointer == PTR_W'(SAMPLES - 1)) ? '0 : ring_pointer + PTR_W'(1);
  end

  // The read is launched at acceptance so the old entry is ready in S_UPDATE.
  assign ring_raddr = ptr_next;
  assign ring_we    = (state == S_UPDATE);

  hbr_ram #(
    .WIDTH (ADC_BITS),
    .DEPTH (SAMPLES)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_pointer),
    .wdata (sample),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // Old ring entry; never-written entries read as zero.
  logic [SUM_W-1:0] old_sample;
  assign old_sample = ring_valid[ring_pointer] ? SUM_W'(ring_rdata) : '0;

  // One restoring divider step.
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   trial_diff;
  logic              trial_ge;
  always_comb begin
    trial      = {rem, quo[PROD_W-1]};
    trial_diff = trial - {1'b0, divisor};
    trial_ge   = (trial >= {1'b0, divisor});
  end

  // Saturated current estimate and overcurrent flag from the quotient.
  logic [CUR_W-1:0] cur;
  logic             over;
  always_comb begin
    cur  = (|quo[PROD_W-1:CUR_W]) ? CUR_MAX : quo[CUR_W-1:0];
    over = (cur >= trip_current);
  end

  // Drive decision for the tick being committed.
  logic [MODE_W-1:0] mode_next;
  logic [TICK_W-1:0] wait_next;
  logic              dir_next;
  logic [DUTY_W-1:0] fwd_next;
  logic [DUTY_W-1:0] bwd_next;

  always_comb begin
    mode_next = drive_mode;
    wait_next = wait_count;
    dir_next  = present_direction;
    fwd_next  = held_forward_duty;
    bwd_next  = held_backward_duty;
    unique case (drive_mode)
      MODE_RUN: begin
        if (over) begin
          if (trip_enable) begin
            fwd_next  = '0;
            bwd_next  = '0;
            mode_next = MODE_TRIP;
          end
        end else if (present_direction != want_dir) begin
          fwd_next  = '0;
          bwd_next  = '0;
          dir_next  = want_dir;
          mode_next = MODE_WAIT;
          wait_next = '0;
        end else if (present_direction) begin
          fwd_next = want_duty;
          bwd_next = '0;
        end else begin
          fwd_next = '0;
          bwd_next = want_duty;
        end
      end
      MODE_WAIT: begin
        if (wait_count >= relay_wait_ticks) begin
          mode_next = MODE_RUN;
          wait_next = '0;
        end else begin
          wait_next = wait_count + TICK_W'(1);
        end
      end
      default: begin
        mode_next = MODE_TRIP;
        fwd_next  = '0;
        bwd_next  = '0;
      end
    endcase
  end

  logic commit;
  assign commit = (state == S_DECIDE) && (!out_valid || !out_stall);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      adc_interval_ticks <= TICK_W'(13);
      relay_wait_ticks   <= TICK_W'(50);
      shunt_value        <= SHUNT_W'(100);
      trip_current       <= CUR_W'(1098644);
      trip_enable        <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_ADC_INTERVAL: adc_interval_ticks <= cfg_data[TICK_W-1:0];
        REG_RELAY_WAIT:   relay_wait_ticks   <= cfg_data[TICK_W-1:0];
        REG_SHUNT:        shunt_value        <= cfg_data[SHUNT_W-1:0];
        REG_TRIP_CURRENT: trip_current       <= cfg_data[CUR_W-1:0];
        REG_TRIP_ENABLE:  trip_enable        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer and tick state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      ring_valid         <= '0;
      ring_pointer       <= '0;
      sample_sum         <= '0;
      interval_count     <= '0;
      drive_mode         <= MODE_RUN;
      wait_count         <= '0;
      present_direction  <= 1'b1;
      held_forward_duty  <= '0;
      held_backward_duty <= '0;
      div_count          <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (take_sample) begin
              interval_count <= '0;
              ring_pointer   <= ptr_next;
              state          <= S_UPDATE;
            end else begin
              interval_count <= ic_inc;
              state          <= S_MUL;
            end
          end
        end
        S_UPDATE: begin
          sample_sum               <= sample_sum - old_sample + SUM_W'(sample);
          ring_valid[ring_pointer] <= 1'b1;
          state                    <= S_MUL;
        end
        S_MUL: begin
          div_count <= '0;
          state     <= S_DIV;
        end
        S_DIV: begin
          div_count <= div_count + DIV_CNT_W'(1);
          if (div_count == DIV_CNT_W'(PROD_W - 1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (commit) begin
            drive_mode         <= mode_next;
            wait_count         <= wait_next;
            present_direction  <= dir_next;
            held_forward_duty  <= fwd_next;
            held_backward_duty <= bwd_next;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Input capture, scaling product, and divider datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      sample    <= adc_sample;
      want_dir  <= target_direction;
      want_duty <= target_duty;
    end
    if (state == S_MUL) begin
      quo     <= PROD_W'(sample_sum) * PROD_W'(CUR_SCALE);
      divisor <= ((shunt_value == '0) ? DIVR_W'(1) : DIVR_W'(shunt_value))
                 * DIVR_W'(SAMPLES);
      rem     <= '0;
    end else if (state == S_DIV) begin
      rem <= trial_ge ? trial_diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      quo <= {quo[PROD_W-2:0], trial_ge};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      forward_duty     <= fwd_next;
      backward_duty    <= bwd_next;
      relay_direction  <= dir_next;
      current_estimate <= cur;
      over_current     <= over;
      mode_now         <= mode_next;
    end
  end

  // A tripped drive stays tripped until reset.
  a_trip_latched: assert property (@(posedge clk) disable iff (rst)
    (drive_mode == MODE_TRIP) |=> (drive_mode == MODE_TRIP))
    else $error("drive mode left the tripped state");

  // The running sum never exceeds a ring of full-scale samples.
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (SUM_W + 1)'(sample_sum) <= (SUM_W + 1)'(SUM_MAX))
    else $error("sample sum out of range");

  // A tripped result drives both legs to zero.
  a_trip_legs_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (mode_now == MODE_TRIP)) |-> (forward_duty == '0 && backward_duty == '0))
    else $error("legs driven while tripped");

  // An accepted transaction always leads into processing, never straight back.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_UPDATE || state == S_MUL))
    else $error("sequencer did not start after acceptance");

  // Waiting for the relay keeps both legs off.
  a_wait_legs_off: assert property (@(posedge clk) disable iff (rst)
    (drive_mode == MODE_WAIT) |-> (held_forward_duty == '0 && held_backward_duty == '0))
    else $error("legs driven while waiting for relay");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the H-bridge relay sequencer: a directed table of
// ticks and register writes, then random ticks checked against a local predictor.
// Depends on hbr_pkg and the hbridge_relay_sequencer RTL.
module testbench
  import hbr_pkg::*;
();

  localparam int TRIP_TOP = 1098644;
  localparam int TICK_TOP = 65535;

  // One result transaction as seen on the output channel.
  typedef struct packed {
    logic [DUTY_W-1:0] fwd;
    logic [DUTY_W-1:0] bwd;
    logic              relay;
    logic [CUR_W-1:0]  est;
    logic              over;
    logic [MODE_W-1:0] mode;
  } drive_result_t;

  // Directed table rows: a plain tick, a tick with a typed-in result, or a register write.
  typedef enum logic [1:0] {ROW_TICK, ROW_CHECKED, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [ADC_BITS-1:0]   adc;
    logic                  dir;
    logic [DUTY_W-1:0]     duty;
    drive_result_t         want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ADC_BITS-1:0]   adc_sample = '0;
  logic                  target_direction = 1'b0;
  logic [DUTY_W-1:0]     target_duty = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DUTY_W-1:0]     forward_duty;
  logic [DUTY_W-1:0]     backward_duty;
  logic                  relay_direction;
  logic [CUR_W-1:0]      current_estimate;
  logic                  over_current;
  logic [MODE_W-1:0]     mode_now;

  int send_pct = 35;
  int recv_pct = 75;
  int mismatch_count = 0;
  drive_result_t drive_due_q [$];
  plan_row_t plan [$];

  // Predictor state and its copy of the configuration registers.
  logic [ADC_BITS-1:0] ring_mem [SAMPLES];
  int unsigned         ring_idx;
  int unsigned         ring_total;
  logic [TICK_W-1:0]   tick_count;
  logic [TICK_W-1:0]   relay_timer;
  logic [MODE_W-1:0]   mode_q;
  logic                dir_q;
  logic [DUTY_W-1:0]   fwd_q;
  logic [DUTY_W-1:0]   bwd_q;
  logic [TICK_W-1:0]   cfg_interval;
  logic [TICK_W-1:0]   cfg_wait;
  logic [TICK_W-1:0]   cfg_shunt;
  logic [CUR_W-1:0]    cfg_trip;
  logic                cfg_trip_en;

  hbridge_relay_sequencer u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .adc_sample       (adc_sample),
    .target_direction (target_direction),
    .target_duty      (target_duty),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .forward_duty     (forward_duty),
    .backward_duty    (backward_duty),
    .relay_direction  (relay_direction),
    .current_estimate (current_estimate),
    .over_current     (over_current),
    .mode_now         (mode_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scaled average current of the ring as it stands now, saturated to the output width.
  function automatic logic [CUR_W-1:0] scaled_now();
    longint unsigned num;
    longint unsigned den;
    num = ring_total;
    num = num * CUR_SCALE;
    den = (cfg_shunt == '0) ? 1 : cfg_shunt;
    den = den * SAMPLES;
    num = num / den;
    return (num > CUR_MAX) ? CUR_MAX : num[CUR_W-1:0];
  endfunction

  // Advances the predictor by one tick and returns the drive outputs it calls for.
  function automatic drive_result_t predict_drive(logic [ADC_BITS-1:0] adc, logic dir,
                                                  logic [DUTY_W-1:0] duty);
    drive_result_t     r;
    logic [TICK_W-1:0] step;
    logic [CUR_W-1:0]  est;
    logic              hot;
    step = (cfg_interval == '0) ? TICK_W'(1) : cfg_interval;
    tick_count = tick_count + 1'b1;
    if (tick_count >= step || tick_count == '0) begin
      tick_count = '0;
      ring_idx = (ring_idx + 1) % SAMPLES;
      ring_total = ring_total - ring_mem[ring_idx] + adc;
      ring_mem[ring_idx] = adc;
    end
    est = scaled_now();
    hot = (est >= cfg_trip);
    case (mode_q)
      MODE_RUN: begin
        if (hot) begin
          // Over current: either hold the present duties or latch off.
          if (cfg_trip_en) begin
            fwd_q = '0;
            bwd_q = '0;
            mode_q = MODE_TRIP;
          end
        end else if (dir_q != dir) begin
          fwd_q = '0;
          bwd_q = '0;
          dir_q = dir;
          mode_q = MODE_WAIT;
          relay_timer = '0;
        end else if (dir_q) begin
          fwd_q = duty;
          bwd_q = '0;
        end else begin
          fwd_q = '0;
          bwd_q = duty;
        end
      end
      MODE_WAIT: begin
        if (relay_timer >= cfg_wait) begin
          mode_q = MODE_RUN;
          relay_timer = '0;
        end else begin
          relay_timer = relay_timer + 1'b1;
        end
      end
      default: begin
        mode_q = MODE_TRIP;
        fwd_q = '0;
        bwd_q = '0;
      end
    endcase
    r = '{fwd_q, bwd_q, dir_q, est, hot, mode_q};
    return r;
  endfunction

  function automatic plan_row_t tick_row(int adc, int dir, int duty);
    plan_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.adc = adc[ADC_BITS-1:0];
    r.dir = dir[0];
    r.duty = duty[DUTY_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t check_row(int adc, int dir, int duty, int fwd, int bwd,
                                          int rel, int est, int over, logic [MODE_W-1:0] mode);
    plan_row_t r;
    r = tick_row(adc, dir, duty);
    r.kind = ROW_CHECKED;
    r.want = '{fwd[DUTY_W-1:0], bwd[DUTY_W-1:0], rel[0], est[CUR_W-1:0], over[0], mode};
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int data);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = data[CFG_DATA_W-1:0];
    return r;
  endfunction

  task automatic report(string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  // Register write on the plain write port; the predictor copy follows.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_ADC_INTERVAL: cfg_interval = data[TICK_W-1:0];
      REG_RELAY_WAIT:   cfg_wait = data[TICK_W-1:0];
      REG_SHUNT:        cfg_shunt = data[TICK_W-1:0];
      REG_TRIP_CURRENT: cfg_trip = data[CUR_W-1:0];
      REG_TRIP_ENABLE:  cfg_trip_en = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (drive_due_q.size() != 0);
  endtask

  // Offers one tick transaction, with random idle cycles ahead of it, and records
  // its expected result once the block takes it.
  task automatic send_tick(logic [ADC_BITS-1:0] adc, logic dir, logic [DUTY_W-1:0] duty,
                           bit typed, drive_result_t typed_val);
    drive_result_t r;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= adc;
    target_direction <= dir;
    target_duty <= duty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_drive(adc, dir, duty);
    drive_due_q.push_back(typed ? typed_val : r);
    @(negedge clk);
  endtask

  // Random register settings for one stretch of ticks; the trip point lands near
  // the present current so that the over-current flag moves both ways.
  task automatic pick_settings();
    int unsigned roll;
    int          v;
    int          w;
    int          trip;
    roll = $urandom_range(9);
    write_reg(REG_ADC_INTERVAL, CFG_DATA_W'((roll == 0) ? 0 : (roll == 1) ? TICK_TOP :
                                            (roll < 4) ? 1 : $urandom_range(2, 12)));
    roll = $urandom_range(19);
    write_reg(REG_RELAY_WAIT, CFG_DATA_W'((roll == 0) ? 0 : (roll == 1) ? TICK_TOP :
                                          $urandom_range(1, 30)));
    roll = $urandom_range(9);
    write_reg(REG_SHUNT, CFG_DATA_W'((roll == 0) ? 0 : (roll == 1) ? 1 :
                                     (roll == 2) ? TICK_TOP :
                                     (roll == 3) ? $urandom_range(1, TICK_TOP) :
                                     $urandom_range(20, 200)));
    w = scaled_now() / 8 + 3;
    v = scaled_now() + $urandom_range(0, 2 * w);
    roll = $urandom_range(9);
    if (roll == 0) trip = 0;
    else if (roll == 1 || v - w > TRIP_TOP) trip = TRIP_TOP;
    else trip = (v < w) ? 0 : v - w;
    write_reg(REG_TRIP_CURRENT, CFG_DATA_W'(trip));
  endtask

  // A stretch of ticks around one sample level, with occasional direction changes
  // and some fully random ticks mixed in.
  task automatic run_segment(int count);
    int   level;
    int   spread;
    int   v;
    logic heading;
    level = $urandom_range(0, 1023);
    spread = $urandom_range(0, 300);
    heading = dir_q;
    repeat (count) begin
      if ($urandom_range(99) == 0) settle();
      if ($urandom_range(99) < 10) begin
        send_tick(ADC_BITS'($urandom), 1'($urandom), DUTY_W'($urandom), 1'b0, '0);
      end else begin
        if ($urandom_range(99) < 8) heading = ~heading;
        case ($urandom_range(19))
          0: v = 0;
          1: v = 1023;
          default: begin
            v = level + $urandom_range(0, 2 * spread) - spread;
            if (v < 0) v = 0;
            else if (v > 1023) v = 1023;
          end
        endcase
        send_tick(v[ADC_BITS-1:0], heading, DUTY_W'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
  endtask

  // Receiver stalls at random at the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_pct);
  end

  // Compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    drive_result_t got;
    drive_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{forward_duty, backward_duty, relay_direction, current_estimate, over_current,
              mode_now};
      if (drive_due_q.size() == 0) begin
        report("result transaction with nothing expected");
      end else begin
        want = drive_due_q.pop_front();
        if (got.fwd !== want.fwd)
          report($sformatf("forward_duty got %0d expected %0d", got.fwd, want.fwd));
        if (got.bwd !== want.bwd)
          report($sformatf("backward_duty got %0d expected %0d", got.bwd, want.bwd));
        if (got.relay !== want.relay)
          report($sformatf("relay_direction got %0d expected %0d", got.relay, want.relay));
        if (got.est !== want.est)
          report($sformatf("current_estimate got %0d expected %0d", got.est, want.est));
        if (got.over !== want.over)
          report($sformatf("over_current got %0d expected %0d", got.over, want.over));
        if (got.mode !== want.mode)
          report($sformatf("mode_now got %0d expected %0d", got.mode, want.mode));
      end
    end
  end

  // Main stimulus.
  initial begin
    foreach (ring_mem[i]) ring_mem[i] = '0;
    ring_idx = 0;
    ring_total = 0;
    tick_count = '0;
    relay_timer = '0;
    mode_q = MODE_RUN;
    dir_q = 1'b1;
    fwd_q = '0;
    bwd_q = '0;
    cfg_interval = 13;
    cfg_wait = 50;
    cfg_shunt = 100;
    cfg_trip = CUR_W'(TRIP_TOP);
    cfg_trip_en = 1'b0;

    // Directed table: duty extremes, direction change and wait, zero interval and
    // zero shunt, holding while over current, long waits cut short.
    plan = '{
      check_row(1023, 1, 255, 255, 0, 1, 0, 0, MODE_RUN),
      check_row(0, 1, 0, 0, 0, 1, 0, 0, MODE_RUN),
      check_row(300, 0, 200, 0, 0, 0, 0, 0, MODE_WAIT),
      reg_row(REG_RELAY_WAIT, 0),
      check_row(5, 0, 9, 0, 0, 0, 0, 0, MODE_RUN),
      check_row(6, 0, 255, 0, 255, 0, 0, 0, MODE_RUN),
      reg_row(REG_ADC_INTERVAL, 0),
      reg_row(REG_SHUNT, 0),
      tick_row(1023, 0, 1),
      reg_row(REG_TRIP_CURRENT, 0),
      tick_row(1023, 1, 50),
      tick_row(0, 0, 99),
      reg_row(REG_TRIP_CURRENT, TRIP_TOP),
      reg_row(REG_SHUNT, TICK_TOP),
      tick_row(1023, 1, 10),
      tick_row(0, 1, 10),
      tick_row(1023, 1, 255),
      reg_row(REG_RELAY_WAIT, TICK_TOP),
      reg_row(REG_ADC_INTERVAL, TICK_TOP),
      tick_row(1, 0, 3),
      tick_row(700, 1, 44),
      tick_row(1023, 0, 255),
      tick_row(0, 0, 0),
      reg_row(REG_RELAY_WAIT, 2),
      tick_row(512, 0, 17),
      tick_row(513, 0, 128),
      tick_row(1022, 0, 254),
      reg_row(REG_TRIP_ENABLE, 1),
      tick_row(512, 0, 100),
      reg_row(REG_TRIP_ENABLE, 0)
    };

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_REG: begin
          settle();
          write_reg(plan[i].idx, plan[i].data);
        end
        ROW_CHECKED: send_tick(plan[i].adc, plan[i].dir, plan[i].duty, 1'b1, plan[i].want);
        default: send_tick(plan[i].adc, plan[i].dir, plan[i].duty, 1'b0, '0);
      endcase
    end

    // Random part in three idling phases: sender-light, receiver-light, none.
    for (int ph = 0; ph < 3; ph++) begin
      settle();
      send_pct = (ph == 0) ? 35 : (ph == 1) ? 75 : 0;
      recv_pct = (ph == 0) ? 75 : (ph == 1) ? 35 : 0;
      repeat (5) begin
        settle();
        pick_settings();
        run_segment(103);
      end
    end

    // Latch a trip, then show it holds even with the trip disabled again.
    settle();
    write_reg(REG_RELAY_WAIT, 0);
    write_reg(REG_TRIP_ENABLE, 1);
    write_reg(REG_TRIP_CURRENT, 0);
    repeat (6) send_tick(ADC_BITS'($urandom), 1'($urandom), DUTY_W'($urandom), 1'b0, '0);
    settle();
    write_reg(REG_TRIP_ENABLE, 0);
    write_reg(REG_TRIP_CURRENT, CFG_DATA_W'(TRIP_TOP));
    repeat (6) send_tick(ADC_BITS'($urandom), 1'($urandom), DUTY_W'($urandom), 1'b0, '0);

    settle();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

[files.f]
rtl/hbr_pkg.sv
rtl/hbr_ram.sv
rtl/hbridge_relay_sequencer.sv
tb/testbench.sv
